@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define PILE_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pile assertion failed");

// checked on every clock edge, reset included
`define PILE_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("pile assertion failed");

`endif

@@ sv/pile_pkg.sv @@
`timescale 1ns / 1ps
package pile_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [3:0] {
        CMD_CREATE     = 4'd0,
        CMD_DESTROY    = 4'd1,
        CMD_CLEAR      = 4'd2,
        CMD_EMPTY      = 4'd3,
        CMD_LENGTH     = 4'd4,
        CMD_GET        = 4'd5,
        CMD_LOCATE     = 4'd6,
        CMD_PRIOR      = 4'd7,
        CMD_NEXT       = 4'd8,
        CMD_INSERT     = 4'd9,
        CMD_DELETE     = 4'd10,
        CMD_READALL    = 4'd11,
        CMD_SORT       = 4'd12,
        CMD_REVERSE    = 4'd13,
        CMD_DELNTH_END = 4'd14
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_NOINIT  = 3'd1,
        STAT_BAD     = 3'd2,
        STAT_EXISTS  = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        C_HOLD,
        C_INS,
        C_DEL,
        C_SORT,
        C_REV
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   count;
        logic               phase;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

@@ sv/position_indexed_list_engine.sv @@
`timescale 1ns / 1ps
// Bounded list of up to 32 signed words held in a row of cells. A command is
// taken when start is high and busy is low; its results come back one per
// cycle on the result ports, each marked by done for one cycle, and must be
// taken then since the receiver cannot stall. Most commands answer in the
// cycle after the transaction and leave busy low. Sort and reverse run one
// neighbor exchange round per cycle across the cells and hold busy
// meanwhile. Read all streams one element per cycle, with last set on the
// final one.
`include "assert_macros.svh"
module position_indexed_list_engine
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [3:0]                           cmd,
    input  logic [7:0]                           position,
    input  logic signed [31:0]                   value,
    output logic                                 done,
    output logic [2:0]                           status,
    output logic signed [31:0]                   data_out,
    output logic [5:0]                           index_out,
    output logic                                 flag,
    output logic                                 last
);

    localparam int CAP   = pile_pkg::CAPACITY;
    localparam int IDX_W = pile_pkg::IDX_W;
    localparam int CNT_W = pile_pkg::CNT_W;
    localparam int DW    = pile_pkg::DATA_W;

    pile_pkg::state_t     state_reg, state_next;
    logic                 exists_reg, exists_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     round_reg, round_next;
    logic                 rev_reg, rev_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;

    logic                 done_reg, done_next;
    pile_pkg::status_t    status_reg, status_next;
    logic signed [DW-1:0] data_reg, data_next;
    logic [5:0]           index_reg, index_next;
    logic                 flag_reg, flag_next;
    logic                 last_reg, last_next;

    pile_pkg::cell_ctl_t  ctl;
    logic signed [DW-1:0] cell_data [CAP];
    logic [CAP-1:0]       cell_match;

    logic                 accept;
    logic [8:0]           pos9;
    logic [8:0]           cnt9;
    logic                 pos_in_list;
    logic                 pos_ins_ok;

    logic                 loc_found, pri_found, nxt_found;
    logic [IDX_W-1:0]     loc_idx, pri_idx, nxt_idx;
    logic [CNT_W-1:0]     ptr_plus;

    assign busy   = (state_reg != pile_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign pos9        = {1'b0, position};
    assign cnt9        = 9'(count_reg);
    assign pos_in_list = (pos9 >= 9'd1) && (pos9 <= cnt9);
    assign pos_ins_ok  = (pos9 >= 9'd1) && (pos9 <= cnt9 + 9'd1);
    assign ptr_plus    = {1'b0, ptr_reg} + CNT_W'(1);

    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cell
            logic signed [DW-1:0] left_d;
            logic signed [DW-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[g-1];
            end
            if (g == CAP - 1)
            begin : g_end
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[g+1];
            end
            pile_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (IDX_W'(g)),
                .ctl        (ctl),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    // first match searches for locate, prior and next
    always_comb
    begin
        loc_found = 1'b0;
        pri_found = 1'b0;
        nxt_found = 1'b0;
        loc_idx   = '0;
        pri_idx   = '0;
        nxt_idx   = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (cell_match[i] && CNT_W'(i) < count_reg)
            begin
                loc_found = 1'b1;
                loc_idx   = IDX_W'(i);
                if (i >= 1)
                begin
                    pri_found = 1'b1;
                    pri_idx   = IDX_W'(i);
                end
                if (CNT_W'(i) + CNT_W'(1) < count_reg)
                begin
                    nxt_found = 1'b1;
                    nxt_idx   = IDX_W'(i);
                end
            end
        end
    end

    // cell control for insert, delete and exchange rounds
    always_comb
    begin
        ctl.op    = pile_pkg::C_HOLD;
        ctl.idx   = '0;
        ctl.count = count_reg;
        ctl.phase = round_reg[0];
        ctl.value = value;
        if (state_reg == pile_pkg::ST_ROUND)
        begin
            ctl.op = rev_reg ? pile_pkg::C_REV : pile_pkg::C_SORT;
        end
        else if (state_reg == pile_pkg::ST_IDLE && accept && exists_reg)
        begin
            if (cmd == pile_pkg::CMD_INSERT)
            begin
                if (pos_ins_ok && count_reg < CNT_W'(CAP))
                begin
                    ctl.op  = pile_pkg::C_INS;
                    ctl.idx = IDX_W'(position - 8'd1);
                end
            end
            else if (cmd == pile_pkg::CMD_DELETE)
            begin
                if (pos_in_list)
                begin
                    ctl.op  = pile_pkg::C_DEL;
                    ctl.idx = IDX_W'(position - 8'd1);
                end
            end
            else if (cmd == pile_pkg::CMD_DELNTH_END)
            begin
                if (pos_in_list)
                begin
                    ctl.op  = pile_pkg::C_DEL;
                    ctl.idx = IDX_W'(cnt9 - pos9);
                end
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        exists_next = exists_reg;
        count_next  = count_reg;
        round_next  = round_reg;
        rev_next    = rev_reg;
        ptr_next    = ptr_reg;
        done_next   = 1'b0;
        status_next = pile_pkg::STAT_OK;
        data_next   = '0;
        index_next  = '0;
        flag_next   = 1'b0;
        last_next   = 1'b0;

        unique case (state_reg)
            pile_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    last_next = 1'b1;
                    unique case (pile_pkg::cmd_t'(cmd))
                        pile_pkg::CMD_CREATE:
                        begin
                            if (exists_reg)
                            begin
                                status_next = pile_pkg::STAT_EXISTS;
                            end
                            else
                            begin
                                exists_next = 1'b1;
                                count_next  = '0;
                            end
                        end
                        pile_pkg::CMD_DESTROY, pile_pkg::CMD_CLEAR,
                        pile_pkg::CMD_EMPTY, pile_pkg::CMD_LENGTH,
                        pile_pkg::CMD_GET, pile_pkg::CMD_LOCATE,
                        pile_pkg::CMD_PRIOR, pile_pkg::CMD_NEXT,
                        pile_pkg::CMD_INSERT, pile_pkg::CMD_DELETE,
                        pile_pkg::CMD_READALL, pile_pkg::CMD_SORT,
                        pile_pkg::CMD_REVERSE, pile_pkg::CMD_DELNTH_END:
                        begin
                            if (!exists_reg)
                            begin
                                status_next = pile_pkg::STAT_NOINIT;
                            end
                            else
                            begin
                                unique case (pile_pkg::cmd_t'(cmd))
                                    pile_pkg::CMD_DESTROY:
                                    begin
                                        exists_next = 1'b0;
                                        count_next  = '0;
                                    end
                                    pile_pkg::CMD_CLEAR:
                                    begin
                                        count_next = '0;
                                    end
                                    pile_pkg::CMD_EMPTY:
                                    begin
                                        flag_next = (count_reg == '0);
                                    end
                                    pile_pkg::CMD_LENGTH:
                                    begin
                                        index_next = 6'(count_reg);
                                    end
                                    pile_pkg::CMD_GET:
                                    begin
                                        if (pos_in_list)
                                        begin
                                            data_next = cell_data[IDX_W'(position - 8'd1)];
                                        end
                                        else
                                        begin
                                            status_next = pile_pkg::STAT_BAD;
                                        end
                                    end
                                    pile_pkg::CMD_LOCATE:
                                    begin
                                        if (loc_found)
                                        begin
                                            index_next = 6'(loc_idx) + 6'd1;
                                        end
                                        else
                                        begin
                                            status_next = pile_pkg::STAT_BAD;
                                        end
                                    end
                                    pile_pkg::CMD_PRIOR:
                                    begin
                                        if (pri_found)
                                        begin
                                            data_next = cell_data[pri_idx - IDX_W'(1)];
                                        end
                                        else
                                        begin
                                            status_next = pile_pkg::STAT_BAD;
                                        end
                                    end
                                    pile_pkg::CMD_NEXT:
                                    begin
                                        if (nxt_found)
                                        begin
                                            data_next = cell_data[nxt_idx + IDX_W'(1)];
                                        end
                                        else
                                        begin
                                            status_next = pile_pkg::STAT_BAD;
                                        end
                                    end
                                    pile_pkg::CMD_INSERT:
                                    begin
                                        if (!pos_ins_ok)
                                        begin
                                            status_next = pile_pkg::STAT_BAD;
                                        end
                                        else if (count_reg >= CNT_W'(CAP))
                                        begin
                                            status_next = pile_pkg::STAT_FULL;
                                        end
                                        else
                                        begin
                                            count_next = count_reg + CNT_W'(1);
                                        end
                                    end
                                    pile_pkg::CMD_DELETE, pile_pkg::CMD_DELNTH_END:
                                    begin
                                        if (pos_in_list)
                                        begin
                                            data_next  = cell_data[ctl.idx];
                                            count_next = count_reg - CNT_W'(1);
                                        end
                                        else
                                        begin
                                            status_next = pile_pkg::STAT_BAD;
                                        end
                                    end
                                    pile_pkg::CMD_READALL:
                                    begin
                                        if (count_reg == '0)
                                        begin
                                            status_next = pile_pkg::STAT_BAD;
                                        end
                                        else
                                        begin
                                            done_next  = 1'b0;
                                            last_next  = 1'b0;
                                            ptr_next   = '0;
                                            state_next = pile_pkg::ST_RUN;
                                        end
                                    end
                                    pile_pkg::CMD_SORT, pile_pkg::CMD_REVERSE:
                                    begin
                                        if (count_reg > CNT_W'(1))
                                        begin
                                            done_next  = 1'b0;
                                            last_next  = 1'b0;
                                            round_next = '0;
                                            rev_next   = (pile_pkg::cmd_t'(cmd) ==
                                                          pile_pkg::CMD_REVERSE);
                                            state_next = pile_pkg::ST_ROUND;
                                        end
                                    end
                                    default:
                                    begin
                                        status_next = pile_pkg::STAT_BAD;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            status_next = pile_pkg::STAT_BAD;
                        end
                    endcase
                end
            end
            pile_pkg::ST_ROUND:
            begin
                round_next = round_reg + CNT_W'(1);
                if (round_reg == count_reg - CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    last_next  = 1'b1;
                    state_next = pile_pkg::ST_IDLE;
                end
            end
            pile_pkg::ST_RUN:
            begin
                done_next  = 1'b1;
                data_next  = cell_data[ptr_reg];
                index_next = 6'(ptr_plus);
                ptr_next   = ptr_reg + IDX_W'(1);
                if (ptr_plus == count_reg)
                begin
                    last_next  = 1'b1;
                    state_next = pile_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pile_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pile_pkg::ST_IDLE;
            exists_reg <= 1'b0;
            count_reg  <= '0;
            round_reg  <= '0;
            rev_reg    <= 1'b0;
            ptr_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= pile_pkg::STAT_OK;
            data_reg   <= '0;
            index_reg  <= '0;
            flag_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            exists_reg <= exists_next;
            count_reg  <= count_next;
            round_reg  <= round_next;
            rev_reg    <= rev_next;
            ptr_reg    <= ptr_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            data_reg   <= data_next;
            index_reg  <= index_next;
            flag_reg   <= flag_next;
            last_reg   <= last_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign index_out = index_reg;
    assign flag      = flag_reg;
    assign last      = last_reg;

    `PILE_ASSERT(a_run_continues, done_reg && !last_reg |=> done_reg)
    `PILE_ASSERT(a_count_bound, count_reg <= CNT_W'(CAP))
    `PILE_ASSERT(a_no_list_empty, !exists_reg |-> count_reg == '0)
    `PILE_ASSERT(a_idle_after_last, done_reg && last_reg && $past(busy) |-> !busy)
    `PILE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done_reg && !busy)

endmodule

@@ sv/pile_cell.sv @@
`timescale 1ns / 1ps
module pile_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [pile_pkg::IDX_W-1:0]           cell_index,
    input  pile_pkg::cell_ctl_t                  ctl,
    input  logic signed [pile_pkg::DATA_W-1:0]   left_data,
    input  logic signed [pile_pkg::DATA_W-1:0]   right_data,
    output logic signed [pile_pkg::DATA_W-1:0]   data,
    output logic                                 match
);

    logic signed [pile_pkg::DATA_W-1:0] data_reg;
    logic signed [pile_pkg::DATA_W-1:0] data_next;
    logic [pile_pkg::CNT_W-1:0]         pos_ext;
    logic [pile_pkg::CNT_W-1:0]         pos_plus;

    assign pos_ext  = {1'b0, cell_index};
    assign pos_plus = pos_ext + pile_pkg::CNT_W'(1);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            pile_pkg::C_HOLD:
            begin
                data_next = data_reg;
            end
            pile_pkg::C_INS:
            begin
                if (cell_index == ctl.idx)
                begin
                    data_next = ctl.value;
                end
                else if (cell_index > ctl.idx)
                begin
                    data_next = left_data;
                end
            end
            pile_pkg::C_DEL:
            begin
                if (cell_index >= ctl.idx)
                begin
                    data_next = right_data;
                end
            end
            pile_pkg::C_SORT, pile_pkg::C_REV:
            begin
                if (cell_index[0] == ctl.phase)
                begin
                    if (pos_plus < ctl.count)
                    begin
                        if (ctl.op == pile_pkg::C_REV || right_data < data_reg)
                        begin
                            data_next = right_data;
                        end
                    end
                end
                else if (cell_index != '0 && pos_ext < ctl.count)
                begin
                    if (ctl.op == pile_pkg::C_REV || data_reg < left_data)
                    begin
                        data_next = left_data;
                    end
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data  = data_reg;
    assign match = (data_reg == ctl.value);

endmodule
